>>> rtl/rcak_pkg.sv
// Shared types and constants for the relative-to-absolute knob mapper.
// No dependencies; every other file imports this package.
package rcak_pkg;

  localparam int MAP_SLOTS      = 8;
  localparam int KNOB_COUNT_DEF = 8;
  localparam int MAP_W          = 11;
  localparam int MAP_IDX_W      = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int VAL_W          = 7;
  localparam int FRAME_W        = 16;
  localparam int COUNT_W        = 3;
  localparam int BYTE_W         = 8;

  localparam logic [3:0]       CC_NIBBLE     = 4'hB;
  localparam logic [VAL_W-1:0] STEP_NONE     = 7'd0;
  localparam logic [VAL_W-1:0] STEP_HALF     = 7'd64;
  localparam logic [VAL_W-1:0] VALUE_MAX     = 7'd127;
  localparam logic [COUNT_W-1:0] GEN_COUNT   = 3'd3;
  localparam logic [MAP_W-1:0] MAP_RESET_BASE = 11'd102;

  // One classified event waiting for the back end.
  typedef struct packed {
    logic [FRAME_W-1:0]   frame;
    logic [COUNT_W-1:0]   count;
    logic [BYTE_W-1:0]    status;
    logic [BYTE_W-1:0]    first;
    logic [BYTE_W-1:0]    second;
    logic [BYTE_W-1:0]    third;
    logic [MAP_SLOTS-1:0] mask;
  } entry_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  status;
    logic [BYTE_W-1:0]  first;
    logic [BYTE_W-1:0]  second;
    logic [BYTE_W-1:0]  third;
    logic               last;
  } result_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> rtl/rcak_front.sv
// Front end: accepts events and builds the per-knob match mask.
// Depends on rcak_pkg.
module rcak_front #(
  parameter int KnobCount = rcak_pkg::KNOB_COUNT_DEF
) (
  input  logic [rcak_pkg::MAP_W-1:0]   map_i [rcak_pkg::MAP_SLOTS],
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rcak_pkg::FRAME_W-1:0] frame_offset_i,
  input  logic [rcak_pkg::COUNT_W-1:0] byte_count_i,
  input  logic [rcak_pkg::BYTE_W-1:0]  status_byte_i,
  input  logic [rcak_pkg::BYTE_W-1:0]  first_data_i,
  input  logic [rcak_pkg::BYTE_W-1:0]  second_data_i,
  input  logic [rcak_pkg::BYTE_W-1:0]  third_data_i,
  input  rcak_pkg::fifo_stat_t         fifo_stat_i,
  output logic                         push_o,
  output rcak_pkg::entry_t             entry_o
);
  import rcak_pkg::*;

  logic is_cc;

  assign is_cc      = (status_byte_i[7:4] == CC_NIBBLE);
  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  always_comb begin
    entry_o.frame  = frame_offset_i;
    entry_o.count  = byte_count_i;
    entry_o.status = status_byte_i;
    entry_o.first  = first_data_i;
    entry_o.second = second_data_i;
    entry_o.third  = third_data_i;
    entry_o.mask   = '0;
    // Data bit 7 takes no part in matching.
    for (int k = 0; k < KnobCount; k++) begin
      entry_o.mask[k] = is_cc && (map_i[k][10:7] == status_byte_i[3:0])
                        && (map_i[k][6:0] == first_data_i[6:0]);
    end
  end

endmodule

>>> rtl/rcak_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on rcak_pkg.
module rcak_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rcak_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output rcak_pkg::entry_t     head_o,
  output rcak_pkg::fifo_stat_t stat_o
);
  import rcak_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/rcak_back.sv
// Back end: drives the output register, one matching knob per unstalled cycle.
// Depends on rcak_pkg.
module rcak_back #(
  parameter int KnobCount = rcak_pkg::KNOB_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcak_pkg::entry_t     head_i,
  input  rcak_pkg::fifo_stat_t fifo_stat_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output rcak_pkg::result_t    result_o
);
  import rcak_pkg::*;

  localparam int KnobIdxW = (KnobCount > 1) ? $clog2(KnobCount) : 1;

  logic [VAL_W-1:0]     knob_q [KnobCount];
  logic [KnobCount-1:0] done_q, done_d;
  logic [KnobCount-1:0] rem, after;
  logic [KnobIdxW-1:0]  sel;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 fire;
  logic [VAL_W-1:0]     cur, step, dec, new_val;
  logic [VAL_W:0]       sum;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign fire        = !fifo_stat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    rem = head_i.mask[KnobCount-1:0] & ~done_q;
    sel = '0;
    for (int k = KnobCount - 1; k >= 0; k--) begin
      if (rem[k]) sel = KnobIdxW'(k);
    end
    after = rem & ~(KnobCount'(1) << sel);
  end

  // Relative step: 1..63 up, 65..127 down by 128 minus the code, 0 and 64 hold.
  always_comb begin
    cur  = knob_q[sel];
    step = head_i.second[6:0];
    sum  = {1'b0, cur} + {1'b0, step};
    dec  = STEP_NONE - step;
    priority if (step == STEP_NONE || step == STEP_HALF) begin
      new_val = cur;
    end else if (!step[6]) begin
      new_val = sum[VAL_W] ? VALUE_MAX : sum[VAL_W-1:0];
    end else begin
      new_val = (cur < dec) ? STEP_NONE : cur - dec;
    end
  end

  always_comb begin
    res_d.frame = head_i.frame;
    if (rem == '0) begin
      res_d.count  = head_i.count;
      res_d.status = head_i.status;
      res_d.first  = head_i.first;
      res_d.second = head_i.second;
      res_d.third  = head_i.third;
      res_d.last   = 1'b1;
      done_d       = '0;
      pop_o        = fire;
    end else begin
      res_d.count  = GEN_COUNT;
      res_d.status = {CC_NIBBLE, head_i.status[3:0]};
      res_d.first  = {1'b0, head_i.first[6:0]};
      res_d.second = {1'b0, new_val};
      res_d.third  = '0;
      res_d.last   = (after == '0);
      done_d       = (after == '0) ? '0 : (done_q | (rem & ~after));
      pop_o        = fire && (after == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
      for (int k = 0; k < KnobCount; k++) knob_q[k] <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        done_q      <= done_d;
        if (rem != '0) knob_q[sel] <= new_val;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/relative_cc_to_absolute_knobs_top.sv
// Top level of the relative-to-absolute knob mapper: map registers and wiring.
// Depends on rcak_pkg, rcak_front, rcak_fifo and rcak_back.
//
// Input channel (in_valid_i / in_stall_o): one MIDI event per request. A
// control change whose channel and controller match one or more knob maps
// steps each matching knob by the relative code in the second data byte and
// yields one absolute control change per match, in knob order; anything else
// yields the event unchanged. out_last_o marks the final result of an event.
// Output channel (out_valid_o / out_stall_i): results leave an output register.
// Config channel (cfg_valid_i / cfg_ready_o): writes knob map i at index i;
// always ready, indexes past the last map are dropped. Write only while idle.
// Each accepted event is registered in the queue, and each result then in the
// output register. The back end steps one knob per cycle while the output
// is not stalled: one result per match, one for a pass-through.
// The two-entry queue takes inputs until full while the output is stalled;
// a stalled result holds in the output register. Reset clears all knob values
// to zero and loads maps 0..7 with channel 1, controllers 102..109.
module relative_cc_to_absolute_knobs_top #(
  parameter int KNOB_COUNT = rcak_pkg::KNOB_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rcak_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcak_pkg::MAP_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rcak_pkg::FRAME_W-1:0]   frame_offset_i,
  input  logic [rcak_pkg::COUNT_W-1:0]   byte_count_i,
  input  logic [rcak_pkg::BYTE_W-1:0]    status_byte_i,
  input  logic [rcak_pkg::BYTE_W-1:0]    first_data_i,
  input  logic [rcak_pkg::BYTE_W-1:0]    second_data_i,
  input  logic [rcak_pkg::BYTE_W-1:0]    third_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rcak_pkg::FRAME_W-1:0]   out_frame_o,
  output logic [rcak_pkg::COUNT_W-1:0]   out_count_o,
  output logic [rcak_pkg::BYTE_W-1:0]    out_status_o,
  output logic [rcak_pkg::BYTE_W-1:0]    out_first_o,
  output logic [rcak_pkg::BYTE_W-1:0]    out_second_o,
  output logic [rcak_pkg::BYTE_W-1:0]    out_third_o,
  output logic                           out_last_o
);
  import rcak_pkg::*;

  logic [MAP_W-1:0] map_q [MAP_SLOTS];
  logic             push, pop;
  entry_t           entry, head;
  fifo_stat_t       fifo_stat;
  result_t          result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAP_SLOTS; k++) begin
        map_q[k] <= MAP_RESET_BASE + MAP_W'(k);
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(MAP_SLOTS))) begin
      map_q[cfg_index_i[MAP_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  rcak_front #(
    .KnobCount(KNOB_COUNT)
  ) u_front (
    .map_i          (map_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_offset_i (frame_offset_i),
    .byte_count_i   (byte_count_i),
    .status_byte_i  (status_byte_i),
    .first_data_i   (first_data_i),
    .second_data_i  (second_data_i),
    .third_data_i   (third_data_i),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .entry_o        (entry)
  );

  rcak_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  rcak_back #(
    .KnobCount(KNOB_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign out_frame_o  = result.frame;
  assign out_count_o  = result.count;
  assign out_status_o = result.status;
  assign out_first_o  = result.first;
  assign out_second_o = result.second;
  assign out_third_o  = result.third;
  assign out_last_o   = result.last;

endmodule
